// File: hdl/ftsg_pkg.sv
// Shared constants, types and command codes of the flat triangle span generator.
package ftsg_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int FRACTION_BITS = 16;

   localparam int EDGE_W  = 32;
   localparam int COORD_W = 13;
   localparam int ROW_W   = 13;
   localparam int COL_W   = 17;

   // Restoring division: one quotient bit per cycle over a 29-bit magnitude.
   localparam int DIV_STEPS = COORD_W + FRACTION_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [ROW_W-1:0] ROW_LIMIT = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic signed [COL_W-1:0] COL_LIMIT = COL_W'(SCREEN_WIDTH);

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_NEXT = 1'b1;

   // Division slots: P = (x2-x1)/(y2-y1), Q = (x3-x1)/(y3-y1), R = (x3-x2)/(y3-y2).
   localparam logic [1:0] DIV_P = 2'd0;
   localparam logic [1:0] DIV_Q = 2'd1;
   localparam logic [1:0] DIV_R = 2'd2;

   // Multiply slots of the setup sequence.
   localparam logic [2:0] MUL_MID = 3'd0;
   localparam logic [2:0] MUL_UL  = 3'd1;
   localparam logic [2:0] MUL_UR  = 3'd2;
   localparam logic [2:0] MUL_LL  = 3'd3;
   localparam logic [2:0] MUL_LR  = 3'd4;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DIV_GO   = 7'b0000010,
      S_DIV_WAIT = 7'b0000100,
      S_MUL      = 7'b0001000,
      S_MID      = 7'b0010000,
      S_SETUP    = 7'b0100000,
      S_SPAN     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       load_tri;
      logic       next_req;
      logic       div_start;
      logic [1:0] div_sel;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       mid_en;
      logic       setup_en;
      logic       span_en;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// File: hdl/ftsg_div.sv
// Serial signed divider for edge slopes, truncating toward zero.
module ftsg_div
   import ftsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_div,
   input  logic signed [COORD_W:0]  num_diff,
   input  logic [COORD_W-1:0]       den,
   output logic                     done,
   output logic [EDGE_W-1:0]        quotient
);

   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [COORD_W-1:0]   den_ff;
   logic                 run_ff, neg_ff, done_ff;
   logic [COORD_W:0]     mag;
   logic [COORD_W:0]     shifted;
   logic [COORD_W:0]     trial;
   logic                 fits;
   logic [EDGE_W-1:0]    quo_ext;

   always_comb begin
      mag     = num_diff[COORD_W] ? -num_diff : num_diff;
      shifted = {rem_ff, quo_ff[DIV_STEPS-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
      quo_in  = {quo_ff[DIV_STEPS-2:0], fits};
      quo_ext = {{(EDGE_W-DIV_STEPS){1'b0}}, quo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_div) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_div) begin
         rem_ff <= '0;
         quo_ff <= {mag[COORD_W-1:0], {FRACTION_BITS{1'b0}}};
         den_ff <= den;
         neg_ff <= num_diff[COORD_W];
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ext : quo_ext;

endmodule

// File: hdl/ftsg_dp.sv
// Datapath: vertex sort, slope division, setup multiplies, edge walking and span output.
module ftsg_dp
   import ftsg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic signed [COORD_W-1:0] in_ax,
   input  logic signed [COORD_W-1:0] in_ay,
   input  logic signed [COORD_W-1:0] in_bx,
   input  logic signed [COORD_W-1:0] in_by,
   input  logic signed [COORD_W-1:0] in_cx,
   input  logic signed [COORD_W-1:0] in_cy,
   input  logic [7:0]                in_color,
   output logic                      out_valid,
   output logic [7:0]                out_row,
   output logic [8:0]                out_start,
   output logic [8:0]                out_length,
   output logic [7:0]                out_color,
   output logic                      out_last,
   output logic                      out_none
);

   function automatic logic signed [ROW_W-1:0] clip_top(input logic signed [ROW_W-1:0] y);
      return (y < 0) ? '0 : y;
   endfunction

   function automatic logic signed [ROW_W-1:0] clip_bot(input logic signed [ROW_W-1:0] y);
      return (y >= ROW_LIMIT) ? ROW_LIMIT : y;
   endfunction

   function automatic logic [EDGE_W-1:0] scale_x(input logic signed [COORD_W-1:0] x);
      return {{(EDGE_W-COORD_W-FRACTION_BITS){x[COORD_W-1]}}, x, {FRACTION_BITS{1'b0}}};
   endfunction

   function automatic logic [EDGE_W-1:0] half_of(input logic [EDGE_W-1:0] s);
      return {s[EDGE_W-1], s[EDGE_W-1:1]};
   endfunction

   function automatic logic [COORD_W-1:0] cut_rows(input logic signed [ROW_W-1:0] y);
      logic signed [ROW_W:0] neg;
      neg = -{y[ROW_W-1], y};
      return (y < 0) ? neg[COORD_W-1:0] : '0;
   endfunction

   // Sorted vertices.
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic signed [COORD_W-1:0] x1_in, y1_in, x2_in, y2_in, x3_in, y3_in;
   logic [7:0]                color_ff;

   logic [EDGE_W-1:0] qp_ff, qq_ff, qr_ff;
   logic [EDGE_W-1:0] prod_mid_ff, prod_ul_ff, prod_ur_ff, prod_ll_ff, prod_lr_ff;
   logic [EDGE_W-1:0] mid_ff;

   // Live half.
   logic [EDGE_W-1:0]        left_ff, right_ff, lslope_ff, rslope_ff;
   logic signed [ROW_W-1:0]  cur_ff, end_ff;
   logic                     active_ff, second_ff, lower_ok_ff;
   // Lower half, already clipped and biased.
   logic [EDGE_W-1:0]        lo_left_ff, lo_right_ff, lo_lslope_ff, lo_rslope_ff;
   logic signed [ROW_W-1:0]  lo_top_ff, lo_end_ff;

   logic                     valid_ff;
   logic [7:0]               row_ff, color_out_ff;
   logic [8:0]               start_ff, length_ff;
   logic                     last_ff, none_ff;

   logic signed [COORD_W:0]  div_num;
   logic [COORD_W-1:0]       div_den;
   logic                     div_done;
   logic [EDGE_W-1:0]        div_q;

   logic                     flat_top, flat_bot, swap;
   logic [EDGE_W-1:0]        xs1, xs2, xs3;
   logic [EDGE_W-1:0]        ul0, ur0, uls, urs, ll0, lr0, lls, lrs;
   logic signed [COORD_W:0]  dy21, dy31, dy32;
   logic [EDGE_W-1:0]        mul_a;
   logic [COORD_W-1:0]       mul_b;
   logic [EDGE_W+COORD_W-1:0] mul_full;

   logic signed [ROW_W-1:0]  top_up, bot_up, top_lo, bot_lo;
   logic signed [ROW_W-1:0]  cur_next;
   logic                     lower_go, row_empty;
   logic signed [COL_W-1:0]  col_l, col_r, col_len;

   // Vertex ordering by y; equal y values keep the a, b, c input order.
   always_comb begin
      x1_in = in_ax; y1_in = in_ay;
      x2_in = in_bx; y2_in = in_by;
      x3_in = in_cx; y3_in = in_cy;
      if (in_ay <= in_by) begin
         if (in_ay <= in_cy) begin
            if (in_by <= in_cy) begin
               x1_in = in_ax; y1_in = in_ay; x2_in = in_bx; y2_in = in_by;
               x3_in = in_cx; y3_in = in_cy;
            end else begin
               x1_in = in_ax; y1_in = in_ay; x2_in = in_cx; y2_in = in_cy;
               x3_in = in_bx; y3_in = in_by;
            end
         end else begin
            x1_in = in_cx; y1_in = in_cy; x2_in = in_ax; y2_in = in_ay;
            x3_in = in_bx; y3_in = in_by;
         end
      end else begin
         if (in_by <= in_cy) begin
            if (in_ay <= in_cy) begin
               x1_in = in_bx; y1_in = in_by; x2_in = in_ax; y2_in = in_ay;
               x3_in = in_cx; y3_in = in_cy;
            end else begin
               x1_in = in_bx; y1_in = in_by; x2_in = in_cx; y2_in = in_cy;
               x3_in = in_ax; y3_in = in_ay;
            end
         end else begin
            x1_in = in_cx; y1_in = in_cy; x2_in = in_bx; y2_in = in_by;
            x3_in = in_ax; y3_in = in_ay;
         end
      end
   end

   always_comb begin
      dy21 = {y2_ff[COORD_W-1], y2_ff} - {y1_ff[COORD_W-1], y1_ff};
      dy31 = {y3_ff[COORD_W-1], y3_ff} - {y1_ff[COORD_W-1], y1_ff};
      dy32 = {y3_ff[COORD_W-1], y3_ff} - {y2_ff[COORD_W-1], y2_ff};
      case (cmd.div_sel)
         DIV_P: begin
            div_num = {x2_ff[COORD_W-1], x2_ff} - {x1_ff[COORD_W-1], x1_ff};
            div_den = dy21[COORD_W-1:0];
         end
         DIV_Q: begin
            div_num = {x3_ff[COORD_W-1], x3_ff} - {x1_ff[COORD_W-1], x1_ff};
            div_den = dy31[COORD_W-1:0];
         end
         default: begin
            div_num = {x3_ff[COORD_W-1], x3_ff} - {x2_ff[COORD_W-1], x2_ff};
            div_den = dy32[COORD_W-1:0];
         end
      endcase
   end

   ftsg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start_div (cmd.div_start),
      .num_diff  (div_num),
      .den       (div_den),
      .done      (div_done),
      .quotient  (div_q)
   );

   assign status.div_done = div_done;

   // Edge start points and slopes of both halves.
   always_comb begin
      xs1      = scale_x(x1_ff);
      xs2      = scale_x(x2_ff);
      xs3      = scale_x(x3_ff);
      flat_top = (y1_ff == y2_ff);
      flat_bot = (y2_ff == y3_ff);
      ll0      = '0;
      lr0      = '0;
      lls      = '0;
      lrs      = '0;
      if (flat_top) begin
         swap = !(x1_ff < x2_ff);
         ul0  = swap ? xs2 : xs1;
         ur0  = swap ? xs1 : xs2;
         uls  = swap ? qr_ff : qq_ff;
         urs  = swap ? qq_ff : qr_ff;
      end else if (flat_bot) begin
         swap = !(x2_ff < x3_ff);
         ul0  = xs1;
         ur0  = xs1;
         uls  = swap ? qq_ff : qp_ff;
         urs  = swap ? qp_ff : qq_ff;
      end else begin
         swap = !($signed(qp_ff) < $signed(qq_ff));
         ul0  = xs1;
         ur0  = xs1;
         uls  = swap ? qq_ff : qp_ff;
         urs  = swap ? qp_ff : qq_ff;
         ll0  = swap ? mid_ff : xs2;
         lr0  = swap ? xs2 : mid_ff;
         lls  = swap ? qq_ff : qr_ff;
         lrs  = swap ? qr_ff : qq_ff;
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MUL_MID: begin mul_a = qq_ff; mul_b = dy21[COORD_W-1:0];  end
         MUL_UL:  begin mul_a = uls;   mul_b = cut_rows(y1_ff);    end
         MUL_UR:  begin mul_a = urs;   mul_b = cut_rows(y1_ff);    end
         MUL_LL:  begin mul_a = lls;   mul_b = cut_rows(y2_ff);    end
         default: begin mul_a = lrs;   mul_b = cut_rows(y2_ff);    end
      endcase
      mul_full = mul_a * mul_b;
   end

   always_comb begin
      top_up    = clip_top(y1_ff);
      bot_up    = clip_bot((flat_top || flat_bot) ? y3_ff : y2_ff);
      top_lo    = clip_top(y2_ff);
      bot_lo    = clip_bot(y3_ff);
      lower_go  = lower_ok_ff && !second_ff;
      row_empty = !active_ff || (cur_ff >= end_ff);
      cur_next  = cur_ff + 1'b1;
      col_l     = {left_ff[EDGE_W-1], left_ff[EDGE_W-1:FRACTION_BITS]};
      col_r     = {right_ff[EDGE_W-1], right_ff[EDGE_W-1:FRACTION_BITS]};
      if (col_l < 0) col_l = '0;
      if (col_l > COL_LIMIT) col_l = COL_LIMIT;
      if (col_r >= COL_LIMIT) col_r = COL_LIMIT;
      col_len = (col_r > col_l) ? (col_r - col_l) : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tri) begin
         x1_ff    <= x1_in; y1_ff <= y1_in;
         x2_ff    <= x2_in; y2_ff <= y2_in;
         x3_ff    <= x3_in; y3_ff <= y3_in;
         color_ff <= in_color;
      end
      if (div_done) begin
         case (cmd.div_sel)
            DIV_P:   qp_ff <= div_q;
            DIV_Q:   qq_ff <= div_q;
            default: qr_ff <= div_q;
         endcase
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_MID: prod_mid_ff <= mul_full[EDGE_W-1:0];
            MUL_UL:  prod_ul_ff  <= mul_full[EDGE_W-1:0];
            MUL_UR:  prod_ur_ff  <= mul_full[EDGE_W-1:0];
            MUL_LL:  prod_ll_ff  <= mul_full[EDGE_W-1:0];
            default: prod_lr_ff  <= mul_full[EDGE_W-1:0];
         endcase
      end
      if (cmd.mid_en) begin
         mid_ff <= xs1 + prod_mid_ff;
      end
      if (cmd.setup_en) begin
         left_ff      <= ul0 + prod_ul_ff + half_of(uls);
         right_ff     <= ur0 + prod_ur_ff + half_of(urs);
         lslope_ff    <= uls;
         rslope_ff    <= urs;
         cur_ff       <= top_up;
         end_ff       <= bot_up;
         lo_left_ff   <= ll0 + prod_ll_ff + half_of(lls);
         lo_right_ff  <= lr0 + prod_lr_ff + half_of(lrs);
         lo_lslope_ff <= lls;
         lo_rslope_ff <= lrs;
         lo_top_ff    <= top_lo;
         lo_end_ff    <= bot_lo;
      end else if (cmd.next_req && active_ff && (cur_ff >= end_ff) && lower_go) begin
         left_ff   <= lo_left_ff;
         right_ff  <= lo_right_ff;
         lslope_ff <= lo_lslope_ff;
         rslope_ff <= lo_rslope_ff;
         cur_ff    <= lo_top_ff;
         end_ff    <= lo_end_ff;
      end else if (cmd.span_en && !row_empty) begin
         left_ff  <= left_ff + lslope_ff;
         right_ff <= right_ff + rslope_ff;
         cur_ff   <= cur_next;
      end
      if (cmd.span_en) begin
         row_ff       <= row_empty ? '0 : cur_ff[7:0];
         start_ff     <= row_empty ? '0 : col_l[8:0];
         length_ff    <= row_empty ? '0 : col_len[8:0];
         color_out_ff <= row_empty ? '0 : color_ff;
         last_ff      <= !row_empty && (cur_next >= end_ff) && !lower_go;
         none_ff      <= row_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         second_ff   <= 1'b0;
         lower_ok_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= cmd.span_en;
         if (cmd.setup_en) begin
            active_ff   <= (y1_ff != y3_ff);
            second_ff   <= 1'b0;
            lower_ok_ff <= !flat_top && !flat_bot && (top_lo < bot_lo);
         end else if (cmd.next_req && active_ff && (cur_ff >= end_ff) && lower_go) begin
            second_ff <= 1'b1;
         end else if (cmd.span_en) begin
            if (row_empty || ((cur_next >= end_ff) && !lower_go)) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_row    = row_ff;
   assign out_start  = start_ff;
   assign out_length = length_ff;
   assign out_color  = color_out_ff;
   assign out_last   = last_ff;
   assign out_none   = none_ff;

endmodule

// File: hdl/ftsg_ctrl.sv
// Controller state machine sequencing triangle setup and span requests.
module ftsg_ctrl
   import ftsg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       func,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type  state_ff, state_in;
   logic [1:0] div_idx_ff, div_idx_in;
   logic [2:0] mul_idx_ff, mul_idx_in;
   logic       take;

   always_comb begin
      take       = (state_ff == S_IDLE) && start;
      state_in   = state_ff;
      div_idx_in = div_idx_ff;
      mul_idx_in = mul_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = (func == FUNC_NEXT) ? S_SPAN : S_DIV_GO;
               div_idx_in = DIV_P;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (status.div_done) begin
               if (div_idx_ff == DIV_R) begin
                  state_in   = S_MUL;
                  mul_idx_in = MUL_MID;
               end else begin
                  state_in   = S_DIV_GO;
                  div_idx_in = div_idx_ff + 1'b1;
               end
            end
         end
         S_MUL: begin
            if (mul_idx_ff == MUL_LR) begin
               state_in = S_MID;
            end else begin
               mul_idx_in = mul_idx_ff + 1'b1;
            end
         end
         S_MID:   state_in = S_SETUP;
         S_SETUP: state_in = S_IDLE;
         S_SPAN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_tri  = take && (func == FUNC_LOAD);
      cmd.next_req  = take && (func == FUNC_NEXT);
      cmd.div_start = (state_ff == S_DIV_GO);
      cmd.div_sel   = div_idx_ff;
      cmd.mul_en    = (state_ff == S_MUL);
      cmd.mul_sel   = mul_idx_ff;
      cmd.mid_en    = (state_ff == S_MID);
      cmd.setup_en  = (state_ff == S_SETUP);
      cmd.span_en   = (state_ff == S_SPAN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_idx_ff <= DIV_P;
         mul_idx_ff <= MUL_MID;
      end else begin
         state_ff   <= state_in;
         div_idx_ff <= div_idx_in;
         mul_idx_ff <= mul_idx_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: hdl/flat_triangle_span_generator_core.sv
// Top level of the flat triangle span generator: controller plus datapath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  request   | start / busy       | req_func, req_vert_{a,b,c}_{x,y}, req_fill_color
//  response  | rsp_valid (strobe) | rsp_span_row/start/length/color, last, no_span
//
// A span request passes through the accept in S_IDLE and then S_SPAN; the result strobe
// is registered from S_SPAN, appears in the next cycle and overlaps the next accept.
// A load transaction runs three serial slope divisions (launch, 29 quotient bits,
// hand-over) that share one divider, then five setup multiplies on one multiplier,
// the midpoint add and the edge setup.
// Synchronous reset leaves no triangle loaded; a span request then returns no_span.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module flat_triangle_span_generator_core
   import ftsg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic signed [COORD_W-1:0] req_vert_a_x,
   input  logic signed [COORD_W-1:0] req_vert_a_y,
   input  logic signed [COORD_W-1:0] req_vert_b_x,
   input  logic signed [COORD_W-1:0] req_vert_b_y,
   input  logic signed [COORD_W-1:0] req_vert_c_x,
   input  logic signed [COORD_W-1:0] req_vert_c_y,
   input  logic [7:0]                req_fill_color,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_span_row,
   output logic [8:0]                rsp_span_start,
   output logic [8:0]                rsp_span_length,
   output logic [7:0]                rsp_span_color,
   output logic                      rsp_last_span,
   output logic                      rsp_no_span
);

   cmd_type    cmd;
   status_type status;

   ftsg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_func),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ftsg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_ax      (req_vert_a_x),
      .in_ay      (req_vert_a_y),
      .in_bx      (req_vert_b_x),
      .in_by      (req_vert_b_y),
      .in_cx      (req_vert_c_x),
      .in_cy      (req_vert_c_y),
      .in_color   (req_fill_color),
      .out_valid  (rsp_valid),
      .out_row    (rsp_span_row),
      .out_start  (rsp_span_start),
      .out_length (rsp_span_length),
      .out_color  (rsp_span_color),
      .out_last   (rsp_last_span),
      .out_none   (rsp_no_span)
   );

endmodule
